[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[hdl/lssp_pkg.sv]
// ----------------------------------------------------------------------------
// lssp_pkg
// Shared constants, datapath op codes and controller/datapath link types.
// ----------------------------------------------------------------------------
package lssp_pkg;

    // Sizing
    localparam int DEF_NODES       = 16;
    localparam int DEF_WEIGHT_BITS = 16;
    localparam int MAX_ROWS        = 16;
    localparam int DIST_BITS       = 22;
    localparam logic [DIST_BITS-1:0] DIST_MAX = 22'h3FFFFF;
    localparam logic [4:0] NODE_COUNT_RESET = 5'd16;

    // Item command codes
    localparam logic CMD_EDGE  = 1'b0;
    localparam logic CMD_ROUTE = 1'b1;

    // Datapath op codes
    typedef logic [3:0] op_t;
    localparam op_t OP_NOP     = 4'd0;
    localparam op_t OP_CLEAR   = 4'd1;
    localparam op_t OP_EDGE_AB = 4'd2;
    localparam op_t OP_EDGE_BA = 4'd3;
    localparam op_t OP_INIT    = 4'd4;
    localparam op_t OP_SEL     = 4'd5;
    localparam op_t OP_MARK    = 4'd6;
    localparam op_t OP_RELAX   = 4'd7;
    localparam op_t OP_EMIT    = 4'd8;

    // Controller to datapath
    typedef struct packed {
        op_t  op;
        logic load;   // latch the item fields
        logic first;  // first step of a scan
        logic last;   // final step of a scan
    } ctl_t;

    // Datapath to controller
    typedef struct packed {
        logic [3:0] n_last;       // node count in use minus one
        logic       src_ok;       // source lies inside the node range
        logic       best_reached; // selected node has a finite distance
    } status_t;

endpackage

[hdl/lssp_ctrl.sv]
// ----------------------------------------------------------------------------
// lssp_ctrl
// Sequencer: clearing pass, edge writes, init / select / relax rounds, emit.
// ----------------------------------------------------------------------------
module lssp_ctrl #(
    parameter int NODES = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           cmd,
    input  lssp_pkg::status_t              status,
    output logic                           busy,
    output lssp_pkg::ctl_t                 ctl,
    output logic [$clog2(NODES*NODES)-1:0] step_idx
);
    import lssp_pkg::*;

    localparam int AW = $clog2(NODES * NODES);
    localparam logic [AW-1:0] CLR_LAST = AW'(NODES * NODES - 1);

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_EDGE_AB  = 4'd2;
    localparam logic [3:0] S_EDGE_BA  = 4'd3;
    localparam logic [3:0] S_START    = 4'd4;
    localparam logic [3:0] S_INIT     = 4'd5;
    localparam logic [3:0] S_SEL      = 4'd6;
    localparam logic [3:0] S_SEL_WAIT = 4'd7;
    localparam logic [3:0] S_MARK     = 4'd8;
    localparam logic [3:0] S_RELAX    = 4'd9;
    localparam logic [3:0] S_EMIT     = 4'd10;

    logic [3:0]    state_reg, state_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic [3:0]    round_reg, round_next;
    logic          last_step;
    logic          final_round;

    assign last_step   = (cnt_reg == AW'(status.n_last));
    assign final_round = (round_reg == status.n_last - 4'd1);
    assign busy        = (state_reg != S_IDLE);
    assign step_idx    = cnt_reg;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        round_next = round_reg;
        ctl.op     = OP_NOP;
        ctl.load   = 1'b0;
        ctl.first  = (cnt_reg == '0);
        ctl.last   = last_step;
        case (state_reg)
            S_CLEAR:
            begin
                ctl.op = OP_CLEAR;
                if (cnt_reg == CLR_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = (cmd == CMD_ROUTE) ? S_START : S_EDGE_AB;
                end
            end
            S_EDGE_AB:
            begin
                ctl.op     = OP_EDGE_AB;
                state_next = S_EDGE_BA;
            end
            S_EDGE_BA:
            begin
                ctl.op     = OP_EDGE_BA;
                state_next = S_IDLE;
            end
            S_START:
            begin
                cnt_next   = '0;
                state_next = status.src_ok ? S_INIT : S_EMIT;
            end
            S_INIT:
            begin
                ctl.op = OP_INIT;
                if (last_step)
                begin
                    cnt_next   = '0;
                    round_next = '0;
                    state_next = S_SEL;
                end
                else
                begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end
            S_SEL:
            begin
                ctl.op = OP_SEL;
                if (last_step)
                begin
                    cnt_next   = '0;
                    state_next = S_SEL_WAIT;
                end
                else
                begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end
            S_SEL_WAIT:
            begin
                state_next = S_MARK;
            end
            S_MARK:
            begin
                ctl.op = OP_MARK;
                if (status.best_reached)
                begin
                    state_next = S_RELAX;
                end
                else if (final_round)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    round_next = round_reg + 4'd1;
                    state_next = S_SEL;
                end
            end
            S_RELAX:
            begin
                ctl.op = OP_RELAX;
                if (last_step)
                begin
                    cnt_next = '0;
                    if (final_round)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        round_next = round_reg + 4'd1;
                        state_next = S_SEL;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end
            S_EMIT:
            begin
                ctl.op = OP_EMIT;
                if (last_step)
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end
            default:
            begin
                cnt_next   = '0;
                state_next = S_CLEAR;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cnt_reg   <= '0;
            round_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            round_reg <= round_next;
        end
    end

endmodule

[hdl/lssp_dpath.sv]
// ----------------------------------------------------------------------------
// lssp_dpath
// Adjacency memory, per-node distance / hop / flag registers, selection and
// relaxation logic, result row registers.
// ----------------------------------------------------------------------------
module lssp_dpath #(
    parameter int NODES       = 16,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  lssp_pkg::ctl_t                 ctl,
    input  logic [$clog2(NODES*NODES)-1:0] step_idx,
    input  logic [3:0]                     node_a,
    input  logic [3:0]                     node_b,
    input  logic [15:0]                    weight,
    input  logic [3:0]                     source,
    input  logic                           cfg_wr_en,
    input  logic [4:0]                     cfg_wr_data,
    output lssp_pkg::status_t              status,
    output logic                           result_strobe,
    output logic [3:0]                     dest_node,
    output logic [21:0]                    distance,
    output logic [3:0]                     next_hop,
    output logic                           reachable,
    output logic                           last
);
    import lssp_pkg::*;

    localparam int R     = (NODES < MAX_ROWS) ? NODES : MAX_ROWS;
    localparam int RW    = $clog2(R);
    localparam int DEPTH = NODES * NODES;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = ((WEIGHT_BITS > DIST_BITS) ? WEIGHT_BITS : DIST_BITS) + 1;

    // Item and config registers
    logic [4:0]             node_count_reg;
    logic [3:0]             a_reg, b_reg, src_reg;
    logic [WEIGHT_BITS-1:0] w_reg;

    // Adjacency memory
    logic [WEIGHT_BITS-1:0] edge_mem [DEPTH];
    logic [WEIGHT_BITS-1:0] rdata_reg;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [WEIGHT_BITS-1:0] mem_wdata;
    logic [AW-1:0]          mem_raddr;

    // Per-node search state
    logic [DIST_BITS-1:0] dist_reg [R];
    logic [RW-1:0]        hop_reg  [R];
    logic                 vis_reg  [R];
    logic                 rch_reg  [R];

    // Running selection
    logic [RW-1:0]        best_u_reg;
    logic [DIST_BITS-1:0] best_dist_reg;
    logic [RW-1:0]        best_hop_reg;
    logic                 best_rch_reg;
    logic                 have_reg;

    // Second stage (follows the memory read)
    op_t                  op_d_reg;
    logic [RW-1:0]        k_d_reg;
    logic                 first_d_reg;
    logic                 last_d_reg;

    logic [4:0]           n_eff;
    logic                 src_ok;
    logic                 edge_ok;
    logic [RW-1:0]        k;
    logic [DIST_BITS-1:0] d_k;
    logic [RW-1:0]        hop_k;
    logic                 vis_k;
    logic                 rch_k;
    logic [SW-1:0]        cand_sum;
    logic [DIST_BITS-1:0] cand;
    logic                 relax_upd;
    logic                 take;
    logic                 have;
    logic                 from_src;
    logic                 row_reach;

    // Node count clamped to the usable range
    always_comb
    begin
        if (node_count_reg < 5'd2)
        begin
            n_eff = 5'd2;
        end
        else if (node_count_reg > 5'(R))
        begin
            n_eff = 5'(R);
        end
        else
        begin
            n_eff = node_count_reg;
        end
    end

    assign src_ok  = ({1'b0, src_reg} < n_eff);
    assign edge_ok = (a_reg != b_reg) && (int'(a_reg) < NODES) && (int'(b_reg) < NODES);
    assign k       = step_idx[RW-1:0];

    assign status.n_last       = 4'(n_eff - 5'd1);
    assign status.src_ok       = src_ok;
    assign status.best_reached = best_rch_reg;

    // Item and config capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NODE_COUNT_RESET;
        end
        else if (cfg_wr_en)
        begin
            node_count_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            a_reg   <= node_a;
            b_reg   <= node_b;
            w_reg   <= WEIGHT_BITS'(weight);
            src_reg <= source;
        end
    end

    // Memory write port: clearing pass and both halves of an edge
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = step_idx;
        mem_wdata = '0;
        case (ctl.op)
            OP_CLEAR:
            begin
                mem_we = 1'b1;
            end
            OP_EDGE_AB:
            begin
                mem_we    = edge_ok;
                mem_waddr = AW'(int'(a_reg) * NODES + int'(b_reg));
                mem_wdata = w_reg;
            end
            OP_EDGE_BA:
            begin
                mem_we    = edge_ok;
                mem_waddr = AW'(int'(b_reg) * NODES + int'(a_reg));
                mem_wdata = w_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Row of the selected node
    assign mem_raddr = AW'(int'(best_u_reg) * NODES + int'(k));

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            edge_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= edge_mem[mem_raddr];
    end

    // Stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_d_reg <= OP_NOP;
        end
        else
        begin
            op_d_reg <= ctl.op;
        end
    end

    always_ff @(posedge clk)
    begin
        k_d_reg     <= k;
        first_d_reg <= ctl.first;
        last_d_reg  <= ctl.last;
    end

    // Per-node reads at the stage index
    assign d_k   = dist_reg[k_d_reg];
    assign hop_k = hop_reg[k_d_reg];
    assign vis_k = vis_reg[k_d_reg];
    assign rch_k = rch_reg[k_d_reg];

    // Relaxation with saturating sum
    assign cand_sum  = SW'(best_dist_reg) + SW'(rdata_reg);
    assign cand      = (cand_sum > SW'(DIST_MAX)) ? DIST_MAX : cand_sum[DIST_BITS-1:0];
    assign relax_upd = !vis_k && (rdata_reg != '0) && (!rch_k || (cand < d_k));
    assign from_src  = (best_u_reg == src_reg[RW-1:0]);

    // Selection: unreached is infinite, ties go to the higher index
    assign have = first_d_reg ? 1'b0 : have_reg;
    assign take = !vis_k && (!have || (rch_k ? !(best_rch_reg && (d_k > best_dist_reg))
                                             : !best_rch_reg));

    // Per-node state updates
    always_ff @(posedge clk)
    begin
        case (op_d_reg)
            OP_INIT:
            begin
                dist_reg[k_d_reg] <= '0;
                vis_reg[k_d_reg]  <= 1'b0;
                rch_reg[k_d_reg]  <= (4'(k_d_reg) == src_reg);
                hop_reg[k_d_reg]  <= (4'(k_d_reg) == src_reg) ? src_reg[RW-1:0] : '0;
            end
            OP_RELAX:
            begin
                if (relax_upd)
                begin
                    dist_reg[k_d_reg] <= cand;
                    rch_reg[k_d_reg]  <= 1'b1;
                    hop_reg[k_d_reg]  <= from_src ? k_d_reg : best_hop_reg;
                end
            end
            default:
            begin
            end
        endcase
        if (ctl.op == OP_MARK)
        begin
            vis_reg[best_u_reg] <= 1'b1;
        end
    end

    // Selection registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg     <= 1'b0;
            best_rch_reg <= 1'b0;
        end
        else if (op_d_reg == OP_SEL)
        begin
            if (take)
            begin
                have_reg     <= 1'b1;
                best_rch_reg <= rch_k;
            end
            else if (first_d_reg)
            begin
                have_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((op_d_reg == OP_SEL) && take)
        begin
            best_u_reg    <= k_d_reg;
            best_dist_reg <= d_k;
            best_hop_reg  <= hop_k;
        end
    end

    // Result rows
    assign row_reach = src_ok && rch_k;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_strobe <= 1'b0;
            last          <= 1'b0;
        end
        else
        begin
            result_strobe <= (op_d_reg == OP_EMIT);
            last          <= (op_d_reg == OP_EMIT) && last_d_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_d_reg == OP_EMIT)
        begin
            dest_node <= 4'(k_d_reg);
            distance  <= row_reach ? d_k : '0;
            next_hop  <= row_reach ? 4'(hop_k) : 4'd0;
            reachable <= row_reach;
        end
    end

endmodule

[hdl/link_state_shortest_path.sv]
// ----------------------------------------------------------------------------
// link_state_shortest_path
// Edge write: both halves are written in the EDGE_AB and EDGE_BA states, then
// the block is ready again. Route: start check, init scan, select / mark /
// relax rounds, emit scan. Rows come one per cycle, the first after the stage
// and output registers. Cost is set by the sequential select and relax scans.
// After reset the adjacency memory is zeroed, with busy high.
// ----------------------------------------------------------------------------
module link_state_shortest_path #(
    parameter int NODES       = lssp_pkg::DEF_NODES,
    parameter int WEIGHT_BITS = lssp_pkg::DEF_WEIGHT_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cmd,
    input  logic [3:0]  node_a,
    input  logic [3:0]  node_b,
    input  logic [15:0] weight,
    input  logic [3:0]  source,
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data,
    output logic        result_strobe,
    output logic [3:0]  dest_node,
    output logic [21:0] distance,
    output logic [3:0]  next_hop,
    output logic        reachable,
    output logic        last
);
    import lssp_pkg::*;

    localparam int AW = $clog2(NODES * NODES);

    ctl_t          ctl;
    status_t       status;
    logic [AW-1:0] step_idx;

    // Sequencer
    lssp_ctrl #(
        .NODES (NODES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .cmd      (cmd),
        .status   (status),
        .busy     (busy),
        .ctl      (ctl),
        .step_idx (step_idx)
    );

    // Datapath
    lssp_dpath #(
        .NODES       (NODES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .step_idx      (step_idx),
        .node_a        (node_a),
        .node_b        (node_b),
        .weight        (weight),
        .source        (source),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .status        (status),
        .result_strobe (result_strobe),
        .dest_node     (dest_node),
        .distance      (distance),
        .next_hop      (next_hop),
        .reachable     (reachable),
        .last          (last)
    );

endmodule

[hdl/lssp_checker.sv]
// ----------------------------------------------------------------------------
// lssp_checker
// Port-level checks on the start handshake and the routing table beats.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lssp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        result_strobe,
    input logic [3:0]  dest_node,
    input logic [21:0] distance,
    input logic [3:0]  next_hop,
    input logic        reachable,
    input logic        last
);

    // An accepted item always raises busy in the next cycle
    `ASSERT_NEXT(a_start_busy, start && !busy, busy)

    // Last flag only on a table beat
    `ASSERT_SAME(a_last_strobe, last, result_strobe)

    // Unreachable rows carry zero cost and zero hop
    `ASSERT_SAME(a_unreach_zero, result_strobe && !reachable, distance == 22'd0 && next_hop == 4'd0)

    // Table beats are back to back until the last one
    `ASSERT_NEXT(a_rows_cont, result_strobe && !last, result_strobe)

    // Destinations count up by one
    `ASSERT_NEXT(a_dest_incr, result_strobe && !last, dest_node == 4'($past(dest_node) + 4'd1))

endmodule

bind link_state_shortest_path lssp_checker u_lssp_checker (.*);
